// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the classifier rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ABMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds during reset
`define ABMC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/abmc_pkg.sv =====
// types, constants and helpers of the best-match acl classifier
`timescale 1ns / 1ps

package abmc_pkg;

    localparam int RULE_COUNT  = 16;
    localparam int IDX_W       = $clog2(RULE_COUNT);
    localparam int GROUP_SIZE  = 4;
    localparam int GROUP_COUNT = RULE_COUNT / GROUP_SIZE;
    localparam int CFG_W       = 5;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int LEN_W       = 6;
    localparam int CLASS_W     = 3;
    localparam int FLAGS_W     = 6;
    localparam int SCORE_W     = 7;

    localparam logic [LEN_W-1:0] MAX_PREFIX = LEN_W'(32);

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_ICMP = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_UDP  = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_TCP  = 3'd3;

    localparam int FLAG_TCP_EN   = 0;
    localparam int FLAG_UDP_EN   = 1;
    localparam int FLAG_ICMP_EN  = 2;
    localparam int FLAG_TCP_ACC  = 3;
    localparam int FLAG_UDP_ACC  = 4;
    localparam int FLAG_ICMP_ACC = 5;

    typedef logic [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  src_net;
        logic [ADDR_W-1:0]  dst_net;
        logic [LEN_W-1:0]   src_len;
        logic [LEN_W-1:0]   dst_len;
        logic [PORT_W-1:0]  src_lo;
        logic [PORT_W-1:0]  src_hi;
        logic [PORT_W-1:0]  dst_lo;
        logic [PORT_W-1:0]  dst_hi;
        logic [FLAGS_W-1:0] flags;
    } rule_entry_t;

    typedef struct packed {
        logic               op;
        logic [IDX_W-1:0]   rule_index;
        logic [ADDR_W-1:0]  source_address;
        logic [ADDR_W-1:0]  dest_address;
        logic [PORT_W-1:0]  source_port_low;
        logic [PORT_W-1:0]  source_port_high;
        logic [PORT_W-1:0]  dest_port_low;
        logic [PORT_W-1:0]  dest_port_high;
        logic [LEN_W-1:0]   source_prefix_len;
        logic [LEN_W-1:0]   dest_prefix_len;
        logic [CLASS_W-1:0] packet_class;
        logic [FLAGS_W-1:0] rule_flags;
    } item_t;

    // pipeline control handed to each stage
    typedef struct packed {
        logic advance;
        logic valid;
    } stage_ctrl_t;

    // best candidate of a group of rules
    typedef struct packed {
        score_t           score;
        logic [IDX_W-1:0] idx;
        logic             accept;
    } cand_t;

    function automatic logic [LEN_W-1:0] sat_len(logic [LEN_W-1:0] len);
        return (len > MAX_PREFIX) ? MAX_PREFIX : len;
    endfunction

    // len is 0..32, shifting all ones right by 32 gives zero
    function automatic logic [ADDR_W-1:0] prefix_mask(logic [LEN_W-1:0] len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

// ===== rtl/core/abmc_if.sv =====
// valid/ready channel interfaces of the classifier
`timescale 1ns / 1ps

interface abmc_item_if import abmc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [IDX_W-1:0]   rule_index;
    logic [ADDR_W-1:0]  source_address;
    logic [ADDR_W-1:0]  dest_address;
    logic [PORT_W-1:0]  source_port_low;
    logic [PORT_W-1:0]  source_port_high;
    logic [PORT_W-1:0]  dest_port_low;
    logic [PORT_W-1:0]  dest_port_high;
    logic [LEN_W-1:0]   source_prefix_len;
    logic [LEN_W-1:0]   dest_prefix_len;
    logic [CLASS_W-1:0] packet_class;
    logic [FLAGS_W-1:0] rule_flags;

    modport source (
        output valid, op, rule_index, source_address, dest_address,
               source_port_low, source_port_high, dest_port_low, dest_port_high,
               source_prefix_len, dest_prefix_len, packet_class, rule_flags,
        input  ready
    );
    modport sink (
        input  valid, op, rule_index, source_address, dest_address,
               source_port_low, source_port_high, dest_port_low, dest_port_high,
               source_prefix_len, dest_prefix_len, packet_class, rule_flags,
        output ready
    );
endinterface

interface abmc_result_if import abmc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             drop;
    logic             matched;
    logic [IDX_W-1:0] winning_index;
    score_t           match_score;

    modport source (
        output valid, drop, matched, winning_index, match_score,
        input  ready
    );
    modport sink (
        input  valid, drop, matched, winning_index, match_score,
        output ready
    );
endinterface

interface abmc_cfg_if import abmc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// ===== rtl/core/abmc_rule_table.sv =====
// rule table storage, loaded by write items
`timescale 1ns / 1ps

module abmc_rule_table import abmc_pkg::*; (
    input  logic                           clk,
    input  stage_ctrl_t                    wr_ctrl,
    input  logic [IDX_W-1:0]               wr_index,
    input  item_t                          wr_item,
    output rule_entry_t [RULE_COUNT-1:0]   rules
);

    rule_entry_t [RULE_COUNT-1:0] rules_reg;
    rule_entry_t                  entry_next;

    always_comb
    begin
        entry_next.src_net = wr_item.source_address;
        entry_next.dst_net = wr_item.dest_address;
        entry_next.src_len = sat_len(wr_item.source_prefix_len);
        entry_next.dst_len = sat_len(wr_item.dest_prefix_len);
        entry_next.src_lo  = wr_item.source_port_low;
        entry_next.src_hi  = wr_item.source_port_high;
        entry_next.dst_lo  = wr_item.dest_port_low;
        entry_next.dst_hi  = wr_item.dest_port_high;
        entry_next.flags   = wr_item.rule_flags;
    end

    // entries hold no reset value, they are undefined until written
    always_ff @(posedge clk)
    begin
        if (wr_ctrl.advance && wr_ctrl.valid)
        begin
            rules_reg[wr_index] <= entry_next;
        end
    end

    assign rules = rules_reg;

endmodule

// ===== rtl/core/abmc_match_stage.sv =====
// per-rule match and score stage, all rules compared in parallel
`timescale 1ns / 1ps

module abmc_match_stage import abmc_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stage_ctrl_t                   ctrl,
    input  item_t                         tuple,
    input  rule_entry_t [RULE_COUNT-1:0]  rules,
    input  logic [CFG_W-1:0]              rules_in_use,
    output logic                          valid,
    output score_t [RULE_COUNT-1:0]       scores,
    output logic [RULE_COUNT-1:0]         accepts
);

    logic                    valid_reg;
    score_t [RULE_COUNT-1:0] score_reg;
    score_t [RULE_COUNT-1:0] score_next;
    logic [RULE_COUNT-1:0]   accept_reg;
    logic [RULE_COUNT-1:0]   accept_next;

    always_comb
    begin
        rule_entry_t e;
        logic        en;
        logic        acc;
        logic        port_ok;
        logic        addr_ok;
        logic        active;
        for (int i = 0; i < RULE_COUNT; i++)
        begin
            e = rules[i];
            case (tuple.packet_class)
                CLASS_ICMP:
                begin
                    en  = e.flags[FLAG_ICMP_EN];
                    acc = e.flags[FLAG_ICMP_ACC];
                end
                CLASS_UDP:
                begin
                    en  = e.flags[FLAG_UDP_EN];
                    acc = e.flags[FLAG_UDP_ACC];
                end
                CLASS_TCP:
                begin
                    en  = e.flags[FLAG_TCP_EN];
                    acc = e.flags[FLAG_TCP_ACC];
                end
                default:
                begin
                    en  = 1'b0;
                    acc = e.flags[FLAG_TCP_ACC];
                end
            endcase
            // icmp carries no ports
            port_ok = (tuple.packet_class == CLASS_ICMP) ||
                      ((e.src_lo <= tuple.source_port_low) &&
                       (tuple.source_port_low <= e.src_hi) &&
                       (e.dst_lo <= tuple.dest_port_low) &&
                       (tuple.dest_port_low <= e.dst_hi));
            addr_ok = (((e.src_net ^ tuple.source_address) & prefix_mask(e.src_len))
                       == '0) &&
                      (((e.dst_net ^ tuple.dest_address) & prefix_mask(e.dst_len))
                       == '0);
            active  = CFG_W'(i) < rules_in_use;
            if (en && port_ok && addr_ok && active)
            begin
                score_next[i] = SCORE_W'(e.src_len) + SCORE_W'(e.dst_len) + SCORE_W'(2);
            end
            else
            begin
                score_next[i] = '0;
            end
            accept_next[i] = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            score_reg  <= score_next;
            accept_reg <= accept_next;
        end
    end

    assign valid   = valid_reg;
    assign scores  = score_reg;
    assign accepts = accept_reg;

endmodule

// ===== rtl/core/abmc_select_tree.sv =====
// two-level registered best-score selection and result register
`timescale 1ns / 1ps

module abmc_select_tree import abmc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  stage_ctrl_t              ctrl,
    input  score_t [RULE_COUNT-1:0]  scores,
    input  logic [RULE_COUNT-1:0]    accepts,
    output logic                     out_valid,
    output logic                     drop,
    output logic                     matched,
    output logic [IDX_W-1:0]         winning_index,
    output score_t                   match_score
);

    logic                     grp_valid_reg;
    cand_t [GROUP_COUNT-1:0]  grp_reg;
    cand_t [GROUP_COUNT-1:0]  grp_next;
    cand_t                    best_next;
    logic                     out_valid_reg;
    logic                     drop_reg;
    logic                     matched_reg;
    logic [IDX_W-1:0]         index_reg;
    score_t                   score_reg;

    // strict compare in ascending order keeps the lowest index on a tie
    always_comb
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            grp_next[g].score  = '0;
            grp_next[g].idx    = '0;
            grp_next[g].accept = 1'b1;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (scores[g * GROUP_SIZE + k] > grp_next[g].score)
                begin
                    grp_next[g].score  = scores[g * GROUP_SIZE + k];
                    grp_next[g].idx    = IDX_W'(g * GROUP_SIZE + k);
                    grp_next[g].accept = accepts[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_comb
    begin
        best_next.score  = '0;
        best_next.idx    = '0;
        best_next.accept = 1'b1;
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            if (grp_reg[g].score > best_next.score)
            begin
                best_next = grp_reg[g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            grp_valid_reg <= ctrl.valid;
            out_valid_reg <= grp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            grp_reg     <= grp_next;
            matched_reg <= (best_next.score != '0);
            drop_reg    <= (best_next.score != '0) && !best_next.accept;
            index_reg   <= best_next.idx;
            score_reg   <= best_next.score;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drop          = drop_reg;
    assign matched       = matched_reg;
    assign winning_index = index_reg;
    assign match_score   = score_reg;

endmodule

// ===== rtl/core/acl_best_match_classifier_core.sv =====
// top level of the five-tuple best-match acl classifier
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channels: item (sink) takes classify tuples and rule writes, selected by op;
// result (source) returns drop, matched, winning_index and match_score, one
// transfer per classify item and none per write item; cfg (sink) writes
// rules_in_use and is always ready, to be used only while the block is idle.
// pipeline: input register, per-rule match stage over all 16 rules in
// parallel, group selection stage, final selection into the result register.
// throughput: one item per cycle while the receiver does not stall.
// a write is applied as it leaves the input register, so later classify
// items see it and earlier ones do not.
// reset clears all valid bits and rules_in_use; rule entries are undefined
// until written.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and item.ready drops; nothing is lost or repeated.
module acl_best_match_classifier_core import abmc_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    abmc_item_if.sink      item,
    abmc_result_if.source  result,
    abmc_cfg_if.sink       cfg
);

    logic                         advance;
    logic                         s1_valid_reg;
    item_t                        s1_item_reg;
    item_t                        item_in;
    logic [CFG_W-1:0]             rules_in_use_reg;
    rule_entry_t [RULE_COUNT-1:0] rules;
    stage_ctrl_t                  wr_ctrl;
    stage_ctrl_t                  match_ctrl;
    stage_ctrl_t                  sel_ctrl;
    logic                         match_valid;
    score_t [RULE_COUNT-1:0]      scores;
    logic [RULE_COUNT-1:0]        accepts;

    assign advance    = !result.valid || result.ready;
    assign item.ready = advance;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        item_in.op                = item.op;
        item_in.rule_index        = item.rule_index;
        item_in.source_address    = item.source_address;
        item_in.dest_address      = item.dest_address;
        item_in.source_port_low   = item.source_port_low;
        item_in.source_port_high  = item.source_port_high;
        item_in.dest_port_low     = item.dest_port_low;
        item_in.dest_port_high    = item.dest_port_high;
        item_in.source_prefix_len = item.source_prefix_len;
        item_in.dest_prefix_len   = item.dest_prefix_len;
        item_in.packet_class      = item.packet_class;
        item_in.rule_flags        = item.rule_flags;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            rules_in_use_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= item.valid;
            end
            if (cfg.valid && cfg.ready)
            begin
                rules_in_use_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg <= item_in;
        end
    end

    assign wr_ctrl.advance    = advance;
    assign wr_ctrl.valid      = s1_valid_reg && (s1_item_reg.op == OP_WRITE);
    assign match_ctrl.advance = advance;
    assign match_ctrl.valid   = s1_valid_reg && (s1_item_reg.op == OP_CLASSIFY);
    assign sel_ctrl.advance   = advance;
    assign sel_ctrl.valid     = match_valid;

    abmc_rule_table u_rule_table (
        .clk      (clk),
        .wr_ctrl  (wr_ctrl),
        .wr_index (s1_item_reg.rule_index),
        .wr_item  (s1_item_reg),
        .rules    (rules)
    );

    abmc_match_stage u_match_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (match_ctrl),
        .tuple        (s1_item_reg),
        .rules        (rules),
        .rules_in_use (rules_in_use_reg),
        .valid        (match_valid),
        .scores       (scores),
        .accepts      (accepts)
    );

    abmc_select_tree u_select_tree (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (sel_ctrl),
        .scores        (scores),
        .accepts       (accepts),
        .out_valid     (result.valid),
        .drop          (result.drop),
        .matched       (result.matched),
        .winning_index (result.winning_index),
        .match_score   (result.match_score)
    );

    `ABMC_ASSERT_RST(a_reset_clears_result, !rst_n |-> !result.valid, "result valid in reset")
    `ABMC_ASSERT(a_result_after_advance, $rose(result.valid) |-> $past(item.ready), "result rose without advance")
    `ABMC_ASSERT(a_no_match_zero, result.valid && !result.matched |-> result.match_score == '0 && result.winning_index == '0 && !result.drop, "no-match result not zero")
    `ABMC_ASSERT(a_match_score_min, result.valid && result.matched |-> result.match_score >= SCORE_W'(2), "matched with score below two")

endmodule
